// ----- sv/jacm_pkg.sv -----
// Shared types and constants for the joystick axis to camera mapper.
// Used by jacm_axis_mem, joystick_axis_camera_mapper_top and the bench; depends on nothing.
package jacm_pkg;

	// Item modes
	localparam logic [2:0] MODE_SAMPLE  = 3'd0;
	localparam logic [2:0] MODE_BEGIN   = 3'd1;
	localparam logic [2:0] MODE_CANCEL  = 3'd2;
	localparam logic [2:0] MODE_SET     = 3'd3;
	localparam logic [2:0] MODE_RESTORE = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_AXIS_COUNT   = 2'd0;
	localparam logic [1:0] CFG_DEFAULT_TILT = 2'd1;
	localparam logic [1:0] CFG_DEFAULT_ZOOM = 2'd2;
	localparam logic [1:0] CFG_THRESHOLD    = 2'd3;

	// Configuration reset values
	localparam logic [3:0]  RST_AXIS_COUNT   = 4'd8;
	localparam logic [2:0]  RST_DEFAULT_TILT = 3'd0;
	localparam logic [2:0]  RST_DEFAULT_ZOOM = 3'd1;
	localparam logic [15:0] RST_THRESHOLD    = 16'd16384;

	// Mapping after reset: defaults are always valid because the axis count is at least two
	localparam logic signed [3:0] AXIS_NONE      = -4'sd1;
	localparam logic signed [3:0] RST_TILT_AXIS  = 4'sd0;
	localparam logic signed [3:0] RST_ZOOM_AXIS  = 4'sd1;

	// Percent scaling
	localparam logic [23:0]       PCT_SCALE = 24'd100;
	localparam logic [15:0]       POS_DEN   = 16'd32767;
	localparam logic signed [7:0] PCT_MAX   = 8'sd100;
	localparam logic signed [7:0] PCT_MIN   = -8'sd100;

	typedef struct packed {
		logic [2:0]         mode;
		logic [2:0]         axis_index;
		logic signed [15:0] axis_value;
		logic               target;
	} jacm_req_t;

	typedef struct packed {
		logic              tilt_update;
		logic signed [7:0] tilt_percent;
		logic              zoom_update;
		logic signed [7:0] zoom_percent;
		logic              value_changed;
		logic              learning;
		logic              learn_target;
		logic              mapping_changed;
		logic signed [3:0] tilt_axis_out;
		logic signed [3:0] zoom_axis_out;
	} jacm_rsp_t;

	// One axis entry of the state memory
	typedef struct packed {
		logic signed [15:0] last;
		logic               seen;
		logic signed [15:0] base;
		logic               base_ok;
	} jacm_entry_t;

endpackage

// ----- sv/joystick_axis_camera_mapper_top.sv -----
// Joystick axis to camera tilt/zoom mapper, top level.
// Depends on jacm_pkg and jacm_axis_mem.
//
// Each request on in_req is either an axis sample or a command (begin learn,
// cancel learn, set mapping, restore defaults) and yields exactly one result
// on out_rsp. The block takes one request per cycle when out_ready stays high.
// A result is offered in the output register after its request passes stage one. The accepting
// edge launches the registered read of the per-axis state memory (last value,
// seen flag, learn baseline). The commit edge, taken once the output register is free,
// computes the step, writes the entry back and registers the result. A request for the
// axis that the previous request just wrote gets that write forwarded, so
// back-to-back samples of one axis need no bubble. Tilt and zoom mappings,
// their last percents and the learn flags live in flip-flops. Learn baselines
// are taken lazily: begin learn clears one bit per axis, and the first sample
// of an axis in that session copies its stored value into the baseline.
// The state is ready right after reset; there is no clearing pass.
// Configuration writes are taken at any time on cfg_valid and must only be
// issued while no request is in flight.
module joystick_axis_camera_mapper_top import jacm_pkg::*; #(
	parameter int NUM_AXES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  jacm_req_t  in_req,
	output logic       out_valid,
	input  logic       out_ready,
	output jacm_rsp_t  out_rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(NUM_AXES);
	localparam int XW = (AW > 3) ? AW : 3;
	localparam int CW = $clog2(NUM_AXES + 16);

	typedef struct packed {
		logic              chg;
		logic signed [3:0] tilt;
		logic signed [3:0] zoom;
	} map_t;

	// Configuration registers
	logic [3:0]  axis_count_q;
	logic [2:0]  def_tilt_q;
	logic [2:0]  def_zoom_q;
	logic [15:0] thresh_q;

	// Scalar state
	logic              learn_on_q;
	logic              learn_for_q;
	logic signed [3:0] tilt_axis_q;
	logic signed [3:0] zoom_axis_q;
	logic signed [7:0] tilt_pct_q;
	logic signed [7:0] zoom_pct_q;
	logic [NUM_AXES-1:0] fresh_q;

	// Stage one: request whose memory read is in flight
	logic              s1_valid_q;
	jacm_req_t         req_s1;
	logic signed [7:0] pct_s1;

	logic          accept;
	logic          commit;
	logic [XW-1:0] in_x;
	logic [XW-1:0] s1_x;
	logic [AW-1:0] in_addr;
	logic [AW-1:0] s1_addr;
	logic [CW-1:0] eff_cnt;
	logic          idx_ok;
	jacm_entry_t   ent;
	jacm_entry_t   wr_ent;
	logic          mem_we;

	logic signed [3:0] dflt_tilt;
	logic signed [3:0] dflt_zoom;
	logic signed [3:0] sidx;
	logic signed [15:0] base;
	logic               base_ok;
	logic [16:0]        dif;
	logic [16:0]        absd;
	map_t               map_res;

	logic              n_learn_on;
	logic              n_learn_for;
	logic signed [3:0] n_tilt;
	logic signed [3:0] n_zoom;
	logic signed [7:0] n_tilt_pct;
	logic signed [7:0] n_zoom_pct;
	logic              f_tilt;
	logic              f_zoom;
	logic              f_map;
	logic              vchg;
	logic              do_stop;
	logic              fresh_set;
	logic              fresh_clr;

	// Scale a raw sample to percent, truncated toward zero
	function automatic logic signed [7:0] to_percent(input logic signed [15:0] raw);
		logic [16:0] mag;
		logic [23:0] prod;
		logic [7:0]  q;
		logic [15:0] rem;
		mag  = raw[15] ? (~{raw[15], raw} + 17'd1) : {1'b0, raw};
		prod = 24'(mag) * PCT_SCALE;
		q    = {1'b0, prod[21:15]};
		// Divide by 32767 for positive values (quotient by 32768 plus one correction step), by 32768 for negative ones
		rem  = {1'b0, prod[14:0]} + 16'(q);
		if (!raw[15] && (rem >= POS_DEN)) begin
			q = q + 8'd1;
		end
		return raw[15] ? $signed(8'd0 - q) : $signed(q);
	endfunction

	// Assign an axis to tilt or zoom, swapping on conflict
	function automatic map_t apply_map(input logic is_tilt, input logic signed [3:0] idx,
			input logic signed [3:0] t, input logic signed [3:0] z);
		map_t r;
		r.chg  = 1'b0;
		r.tilt = t;
		r.zoom = z;
		if (!((is_tilt && (t == idx)) || (!is_tilt && (z == idx)))) begin
			r.chg = 1'b1;
			if (is_tilt) begin
				if (z == idx) r.zoom = t;
				r.tilt = idx;
			end else begin
				if (t == idx) r.tilt = z;
				r.zoom = idx;
			end
			if (r.tilt == r.zoom) begin
				if (is_tilt) r.zoom = AXIS_NONE;
				else r.tilt = AXIS_NONE;
			end
		end
		return r;
	endfunction

	// Configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_count_q <= RST_AXIS_COUNT;
			def_tilt_q   <= RST_DEFAULT_TILT;
			def_zoom_q   <= RST_DEFAULT_ZOOM;
			thresh_q     <= RST_THRESHOLD;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_AXIS_COUNT:   axis_count_q <= cfg_data[3:0];
				CFG_DEFAULT_TILT: def_tilt_q   <= cfg_data[2:0];
				CFG_DEFAULT_ZOOM: def_zoom_q   <= cfg_data[2:0];
				CFG_THRESHOLD:    thresh_q     <= cfg_data;
			endcase
		end
	end

	// Effective axis count and default mapping
	always_comb begin
		eff_cnt = (CW'(axis_count_q) > CW'(NUM_AXES)) ? CW'(NUM_AXES) : CW'(axis_count_q);
		dflt_tilt = (CW'(def_tilt_q) < eff_cnt) ? $signed({1'b0, def_tilt_q}) : AXIS_NONE;
		dflt_zoom = (CW'(def_zoom_q) < eff_cnt) ? $signed({1'b0, def_zoom_q}) : AXIS_NONE;
		if (dflt_zoom == dflt_tilt) begin
			dflt_zoom = AXIS_NONE;
		end
	end

	// Handshake: advance stage one when the output register frees up
	assign commit   = s1_valid_q && (!out_valid || out_ready);
	assign in_ready = !s1_valid_q || commit;
	assign accept   = in_valid && in_ready;

	assign in_x    = XW'(in_req.axis_index);
	assign in_addr = in_x[AW-1:0];
	assign s1_x    = XW'(req_s1.axis_index);
	assign s1_addr = s1_x[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Percent needs only the request, so compute it on entry
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= in_req;
			pct_s1 <= to_percent(in_req.axis_value);
		end
	end

	jacm_axis_mem #(
		.DEPTH(NUM_AXES)
	) u_axis_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.wr_en   (mem_we),
		.wr_addr (s1_addr),
		.wr_data (wr_ent),
		.rd_data (ent)
	);

	// Stage two: compute the step from the entry and the scalar state
	always_comb begin
		idx_ok  = CW'(req_s1.axis_index) < eff_cnt;
		sidx    = $signed({1'b0, req_s1.axis_index});
		// A stale baseline in this learn session is the value held at its start
		base    = (learn_on_q && !fresh_q[s1_addr]) ? ent.last : ent.base;
		base_ok = (learn_on_q && !fresh_q[s1_addr]) ? ent.seen : ent.base_ok;
		dif     = {req_s1.axis_value[15], req_s1.axis_value} - {base[15], base};
		absd    = dif[16] ? (17'd0 - dif) : dif;
		map_res = apply_map(!learn_for_q, sidx, tilt_axis_q, zoom_axis_q);

		n_learn_on  = learn_on_q;
		n_learn_for = learn_for_q;
		n_tilt      = tilt_axis_q;
		n_zoom      = zoom_axis_q;
		n_tilt_pct  = tilt_pct_q;
		n_zoom_pct  = zoom_pct_q;
		f_tilt      = 1'b0;
		f_zoom      = 1'b0;
		f_map       = 1'b0;
		vchg        = 1'b0;
		do_stop     = 1'b0;
		fresh_set   = 1'b0;
		fresh_clr   = 1'b0;
		mem_we      = 1'b0;
		wr_ent.last    = req_s1.axis_value;
		wr_ent.seen    = 1'b1;
		wr_ent.base    = base;
		wr_ent.base_ok = base_ok;

		unique case (req_s1.mode)
			MODE_SAMPLE: begin
				if (idx_ok) begin
					mem_we    = commit;
					fresh_set = learn_on_q;
					vchg      = ent.last != req_s1.axis_value;
					if (vchg && learn_on_q) begin
						if (!ent.seen || !base_ok) begin
							wr_ent.base    = req_s1.axis_value;
							wr_ent.base_ok = 1'b1;
						end else if (absd >= {1'b0, thresh_q}) begin
							// Capture: map the axis and end learn mode
							if (map_res.chg) begin
								do_stop = 1'b1;
								f_map   = 1'b1;
								n_tilt  = map_res.tilt;
								n_zoom  = map_res.zoom;
							end
							n_learn_on  = 1'b0;
							n_learn_for = 1'b0;
						end
					end else if (vchg) begin
						if (sidx == tilt_axis_q) begin
							if (pct_s1 != tilt_pct_q) begin
								n_tilt_pct = pct_s1;
								f_tilt     = 1'b1;
							end
						end else if (sidx == zoom_axis_q) begin
							if (pct_s1 != zoom_pct_q) begin
								n_zoom_pct = pct_s1;
								f_zoom     = 1'b1;
							end
						end
					end
				end
			end
			MODE_BEGIN: begin
				if (eff_cnt != '0) begin
					do_stop     = 1'b1;
					n_learn_on  = 1'b1;
					n_learn_for = req_s1.target;
					fresh_clr   = 1'b1;
				end
			end
			MODE_CANCEL: begin
				n_learn_on  = 1'b0;
				n_learn_for = 1'b0;
			end
			MODE_SET: begin
				if (idx_ok) begin
					n_learn_on  = 1'b0;
					n_learn_for = 1'b0;
					map_res = apply_map(!req_s1.target, sidx, tilt_axis_q, zoom_axis_q);
					if (map_res.chg) begin
						do_stop = 1'b1;
						f_map   = 1'b1;
						n_tilt  = map_res.tilt;
						n_zoom  = map_res.zoom;
					end
				end
			end
			MODE_RESTORE: begin
				n_learn_on  = 1'b0;
				n_learn_for = 1'b0;
				do_stop     = 1'b1;
				if (!((tilt_axis_q == dflt_tilt) && (zoom_axis_q == dflt_zoom))) begin
					f_map  = 1'b1;
					n_tilt = dflt_tilt;
					n_zoom = dflt_zoom;
				end
			end
			default: begin
				// Unused modes: report state with no flags
			end
		endcase

		// Drop any running command to zero
		if (do_stop) begin
			f_tilt     = tilt_pct_q != '0;
			f_zoom     = zoom_pct_q != '0;
			n_tilt_pct = '0;
			n_zoom_pct = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_on_q  <= 1'b0;
			learn_for_q <= 1'b0;
			tilt_axis_q <= RST_TILT_AXIS;
			zoom_axis_q <= RST_ZOOM_AXIS;
			tilt_pct_q  <= '0;
			zoom_pct_q  <= '0;
			fresh_q     <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (commit) begin
				learn_on_q  <= n_learn_on;
				learn_for_q <= n_learn_for;
				tilt_axis_q <= n_tilt;
				zoom_axis_q <= n_zoom;
				tilt_pct_q  <= n_tilt_pct;
				zoom_pct_q  <= n_zoom_pct;
				if (fresh_clr) begin
					fresh_q <= '0;
				end else if (fresh_set) begin
					fresh_q[s1_addr] <= 1'b1;
				end
			end
			if (commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output register holds the result until taken
	always_ff @(posedge clk) begin
		if (commit) begin
			out_rsp.tilt_update     <= f_tilt;
			out_rsp.tilt_percent    <= n_tilt_pct;
			out_rsp.zoom_update     <= f_zoom;
			out_rsp.zoom_percent    <= n_zoom_pct;
			out_rsp.value_changed   <= vchg;
			out_rsp.learning        <= n_learn_on;
			out_rsp.learn_target    <= n_learn_on & n_learn_for;
			out_rsp.mapping_changed <= f_map;
			out_rsp.tilt_axis_out   <= n_tilt;
			out_rsp.zoom_axis_out   <= n_zoom;
		end
	end

	// Tilt and zoom never share an axis
	a_axes_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(tilt_axis_q != zoom_axis_q) || (tilt_axis_q == AXIS_NONE))
		else $error("tilt and zoom mapped to the same axis");

	// A mapping change leaves both commands stopped
	a_map_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_rsp.mapping_changed |->
			(out_rsp.tilt_percent == '0) && (out_rsp.zoom_percent == '0))
		else $error("mapping changed with a running command");

	// Learn target reads zero outside learn mode
	a_target_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_rsp.learning |-> !out_rsp.learn_target)
		else $error("learn target set while not learning");

	// Commands stay within the percent range
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		(tilt_pct_q <= PCT_MAX) && (tilt_pct_q >= PCT_MIN)
			&& (zoom_pct_q <= PCT_MAX) && (zoom_pct_q >= PCT_MIN))
		else $error("percent out of range");

	// A result only appears after a request left stage one
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(s1_valid_q))
		else $error("result without a request in flight");

endmodule

// ----- sv/jacm_axis_mem.sv -----
// Per-axis state memory: one entry per axis, registered read.
// Depends on jacm_pkg for jacm_entry_t; entries never written read as zero.
module jacm_axis_mem import jacm_pkg::*; #(
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  jacm_entry_t   wr_data,
	output jacm_entry_t   rd_data
);

	jacm_entry_t      mem_q [DEPTH];
	jacm_entry_t      rd_q;
	jacm_entry_t      fwd_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;
	logic             fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q  <= mem_q[rd_addr];
			fwd_q <= wr_data;
		end
	end

	// Valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_addr];
				fwd_hit_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	// Forward a write that lands in the same cycle as the read
	assign rd_data = fwd_hit_q ? fwd_q : (rd_vld_q ? rd_q : '0);

endmodule

// ----- bench/mapper_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the joystick axis camera mapper: follows the request, result
// and configuration channels, predicts every result and compares it field by field.
// Depends on jacm_pkg.
module mapper_checker import jacm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  jacm_req_t   in_req,
	input  logic        out_valid,
	input  logic        out_ready,
	input  jacm_rsp_t   out_rsp,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          rsp_pending
);
	localparam int AXES = 8;

	// Register copies
	logic [3:0]  axis_count;
	logic [2:0]  dflt_tilt;
	logic [2:0]  dflt_zoom;
	logic [15:0] threshold;

	// Mapper state
	logic signed [15:0] last_val [AXES];
	logic               seen     [AXES];
	logic signed [15:0] base_val [AXES];
	logic               base_ok  [AXES];
	logic               learn_on;
	logic               learn_for;
	logic signed [3:0]  tilt_ax;
	logic signed [3:0]  zoom_ax;
	logic signed [7:0]  tilt_pct;
	logic signed [7:0]  zoom_pct;
	logic               tilt_upd;
	logic               zoom_upd;
	logic               map_chg;

	jacm_rsp_t rsp_due [$];

	function automatic int live_axes();
		return (axis_count > AXES) ? AXES : int'(axis_count);
	endfunction

	function automatic bit axis_ok(int idx);
		return idx >= 0 && idx < live_axes();
	endfunction

	function automatic void default_map(output logic signed [3:0] t,
			output logic signed [3:0] z);
		t = axis_ok(int'(dflt_tilt)) ? 4'(dflt_tilt) : AXIS_NONE;
		z = axis_ok(int'(dflt_zoom)) ? 4'(dflt_zoom) : AXIS_NONE;
		if (z == t)
			z = AXIS_NONE;
	endfunction

	// Force any running camera command back to zero
	function automatic void stop_cmds();
		if (tilt_pct != 0) begin
			tilt_pct = 0;
			tilt_upd = 1'b1;
		end
		if (zoom_pct != 0) begin
			zoom_pct = 0;
			zoom_upd = 1'b1;
		end
	endfunction

	function automatic void end_learn();
		if (!learn_on)
			return;
		learn_on = 1'b0;
		learn_for = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			base_val[i] = '0;
			base_ok[i] = 1'b0;
		end
	endfunction

	// Assign an axis to tilt (tgt 0) or zoom (tgt 1), swapping on conflict
	function automatic void remap(logic tgt, int idx);
		logic signed [3:0] ax;
		ax = 4'(idx);
		if (!axis_ok(idx))
			return;
		if ((!tgt && tilt_ax == ax) || (tgt && zoom_ax == ax))
			return;
		stop_cmds();
		if (!tgt) begin
			if (zoom_ax == ax)
				zoom_ax = tilt_ax;
			tilt_ax = ax;
		end else begin
			if (tilt_ax == ax)
				tilt_ax = zoom_ax;
			zoom_ax = ax;
		end
		if (tilt_ax == zoom_ax) begin
			if (!tgt)
				zoom_ax = AXIS_NONE;
			else
				tilt_ax = AXIS_NONE;
		end
		tilt_pct = 0;
		zoom_pct = 0;
		map_chg = 1'b1;
	endfunction

	function automatic bit learn_step(int idx, logic signed [15:0] v, bit was_seen);
		int d;
		if (!learn_on)
			return 1'b0;
		if (!was_seen || !base_ok[idx]) begin
			base_val[idx] = v;
			base_ok[idx] = 1'b1;
			return 1'b0;
		end
		d = int'(v) - int'(base_val[idx]);
		if (d < 0)
			d = -d;
		if (d < int'(threshold))
			return 1'b0;
		remap(learn_for, idx);
		end_learn();
		return 1'b1;
	endfunction

	function automatic void camera_step(int idx, logic signed [15:0] v);
		int p;
		p = (v < 0) ? (int'(v) * 100) / 32768 : (int'(v) * 100) / 32767;
		if (p > 100)
			p = 100;
		if (p < -100)
			p = -100;
		if (idx == tilt_ax) begin
			if (tilt_pct != 8'(p)) begin
				tilt_pct = 8'(p);
				tilt_upd = 1'b1;
			end
		end else if (idx == zoom_ax) begin
			if (zoom_pct != 8'(p)) begin
				zoom_pct = 8'(p);
				zoom_upd = 1'b1;
			end
		end
	endfunction

	// Advance the state by one request and return the result it causes
	function automatic jacm_rsp_t map_request(jacm_req_t r);
		jacm_rsp_t res;
		logic signed [3:0] t;
		logic signed [3:0] z;
		int idx;
		bit vchg;
		bit was_seen;
		bit cap;
		idx = int'(r.axis_index);
		vchg = 1'b0;
		tilt_upd = 1'b0;
		zoom_upd = 1'b0;
		map_chg = 1'b0;
		case (r.mode)
		MODE_SAMPLE: begin
			if (axis_ok(idx)) begin
				was_seen = seen[idx];
				vchg = last_val[idx] != r.axis_value;
				last_val[idx] = r.axis_value;
				seen[idx] = 1'b1;
				if (vchg) begin
					cap = learn_step(idx, r.axis_value, was_seen);
					if (!learn_on && !cap)
						camera_step(idx, r.axis_value);
				end
			end
		end
		MODE_BEGIN: begin
			if (live_axes() > 0) begin
				stop_cmds();
				learn_on = 1'b1;
				learn_for = r.target;
				for (int i = 0; i < AXES; i++) begin
					base_val[i] = last_val[i];
					base_ok[i] = seen[i];
				end
			end
		end
		MODE_CANCEL: begin
			end_learn();
		end
		MODE_SET: begin
			if (axis_ok(idx)) begin
				end_learn();
				remap(r.target, idx);
			end
		end
		MODE_RESTORE: begin
			end_learn();
			stop_cmds();
			default_map(t, z);
			if (!(tilt_ax == t && zoom_ax == z)) begin
				tilt_ax = t;
				zoom_ax = z;
				tilt_pct = 0;
				zoom_pct = 0;
				map_chg = 1'b1;
			end
		end
		default: ;
		endcase
		res.tilt_update     = tilt_upd;
		res.tilt_percent    = tilt_pct;
		res.zoom_update     = zoom_upd;
		res.zoom_percent    = zoom_pct;
		res.value_changed   = vchg;
		res.learning        = learn_on;
		res.learn_target    = learn_on & learn_for;
		res.mapping_changed = map_chg;
		res.tilt_axis_out   = tilt_ax;
		res.zoom_axis_out   = zoom_ax;
		return res;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		jacm_rsp_t want;
		if (!arst_n) begin
			axis_count = RST_AXIS_COUNT;
			dflt_tilt  = RST_DEFAULT_TILT;
			dflt_zoom  = RST_DEFAULT_ZOOM;
			threshold  = RST_THRESHOLD;
			for (int i = 0; i < AXES; i++) begin
				last_val[i] = '0;
				seen[i] = 1'b0;
				base_val[i] = '0;
				base_ok[i] = 1'b0;
			end
			learn_on = 1'b0;
			learn_for = 1'b0;
			tilt_pct = 0;
			zoom_pct = 0;
			default_map(tilt_ax, zoom_ax);
			rsp_due.delete();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (rsp_due.size() == 0) begin
					$error("result with no request waiting");
					fail_count++;
				end else begin
					want = rsp_due.pop_front();
					check_field("tilt_update", want.tilt_update, out_rsp.tilt_update);
					check_field("tilt_percent", want.tilt_percent, out_rsp.tilt_percent);
					check_field("zoom_update", want.zoom_update, out_rsp.zoom_update);
					check_field("zoom_percent", want.zoom_percent, out_rsp.zoom_percent);
					check_field("value_changed", want.value_changed, out_rsp.value_changed);
					check_field("learning", want.learning, out_rsp.learning);
					check_field("learn_target", want.learn_target, out_rsp.learn_target);
					check_field("mapping_changed", want.mapping_changed,
						out_rsp.mapping_changed);
					check_field("tilt_axis_out", want.tilt_axis_out, out_rsp.tilt_axis_out);
					check_field("zoom_axis_out", want.zoom_axis_out, out_rsp.zoom_axis_out);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_AXIS_COUNT:   axis_count = cfg_data[3:0];
				CFG_DEFAULT_TILT: dflt_tilt = cfg_data[2:0];
				CFG_DEFAULT_ZOOM: dflt_zoom = cfg_data[2:0];
				CFG_THRESHOLD:    threshold = cfg_data;
				default: ;
				endcase
			end
			if (in_valid && in_ready)
				rsp_due.push_back(map_request(in_req));
		end
		rsp_pending = rsp_due.size();
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the joystick axis camera mapper: makes requests, register
// writes and result back-pressure, and gives the verdict.
// Depends on jacm_pkg, joystick_axis_camera_mapper_top and mapper_checker.
module tb_top;
	import jacm_pkg::*;

	// Modes the block ignores
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	// Run ends here if results stop coming; the slowest correct run is far below
	localparam int CYCLE_LIMIT = 400000;

	// Receiver stall patterns
	typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_COIN} rx_kind_e;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	jacm_req_t   in_req;
	logic        out_valid;
	logic        out_ready;
	jacm_rsp_t   out_rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int fail_count;
	int rsp_pending;
	int cycles = 0;
	int burst_left = 0;

	// What the stimulus believes about the block, used only to aim samples
	logic [3:0]         cur_count = RST_AXIS_COUNT;
	logic [15:0]        cur_thresh = RST_THRESHOLD;
	logic signed [15:0] sent_val [8];

	joystick_axis_camera_mapper_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	mapper_checker watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_req      (in_req),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_rsp     (out_rsp),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.rsp_pending (rsp_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a hung block or a lost result ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: switch between stall patterns at random spans,
	// including long stretches that never stall
	initial begin : receiver
		rx_kind_e kind;
		int span;
		out_ready = 1'b0;
		kind = RX_OPEN;
		span = 0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				kind = rx_kind_e'($urandom_range(RX_OPEN, RX_COIN));
				span = $urandom_range(20, 200);
			end
			span--;
			case (kind)
			RX_OPEN:     out_ready <= 1'b1;
			RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    out_ready <= ($urandom_range(0, 7) == 0);
			RX_PERIODIC: out_ready <= (span % 3 != 0);
			default:     out_ready <= ($urandom_range(0, 1) == 1);
			endcase
		end
	end

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Raw values at the ends of the scaling and around its rounding points
	function automatic int corner_value(int k);
		case (k)
		0:       return -32768;
		1:       return 32767;
		2:       return 0;
		3:       return 1;
		4:       return -1;
		5:       return 327;
		6:       return -328;
		default: return 16384;
		endcase
	endfunction

	function automatic jacm_req_t build_req(logic [2:0] mode, int idx, int val, int tgt);
		jacm_req_t q;
		q.mode       = mode;
		q.axis_index = 3'(idx);
		q.axis_value = 16'(val);
		q.target     = tgt[0];
		return q;
	endfunction

	// Sample request; remember the value so later moves can be aimed at it
	function automatic jacm_req_t sample_at(int k, int v);
		sent_val[k] = 16'(v);
		return build_req(MODE_SAMPLE, k, v, $urandom_range(0, 1));
	endfunction

	// Pick an axis, mostly a live one, sometimes any index at all
	function automatic int pick_axis();
		int live;
		live = (cur_count > 4'd8) ? 8 : int'(cur_count);
		if (live > 0 && $urandom_range(0, 9) != 0)
			return int'($urandom_range(0, live - 1));
		return int'($urandom_range(0, 7));
	endfunction

	function automatic jacm_req_t random_req();
		int pick;
		int a;
		int v;
		a = pick_axis();
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			case ($urandom_range(0, 3))
			0:       v = int'($urandom_range(0, 65535)) - 32768;
			1:       v = corner_value($urandom_range(0, 7));
			2:       v = sent_val[a];
			default: v = int'(sent_val[a]) + int'($urandom_range(0, 2000)) - 1000;
			endcase
			return sample_at(a, clamp16(v));
		end
		if (pick < 70)
			return build_req(MODE_BEGIN, a, $urandom, $urandom_range(0, 1));
		if (pick < 76)
			return build_req(MODE_CANCEL, a, $urandom, $urandom_range(0, 1));
		if (pick < 86)
			return build_req(MODE_SET, a, $urandom, $urandom_range(0, 1));
		if (pick < 93)
			return build_req(MODE_RESTORE, a, $urandom, $urandom_range(0, 1));
		return build_req(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), a, $urandom,
			$urandom_range(0, 1));
	endfunction

	// Send one request; open a random gap whenever the current burst runs out
	task automatic push_req(input jacm_req_t r);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
			repeat ($urandom_range(1, 8)) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_req <= r;
		// hold the request until the block takes it
		do @(posedge clk); while (!in_ready);
	endtask

	// Hold off new requests until every result is back and the pipe is empty
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rsp_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Well-formed learn session: begin, a few small moves that set baselines,
	// then usually one move past the threshold on the chosen axis
	task automatic learn_session(inout int sent);
		int a;
		int k;
		int d;
		int tv;
		a = pick_axis();
		push_req(build_req(MODE_BEGIN, $urandom, $urandom, $urandom_range(0, 1)));
		sent++;
		repeat ($urandom_range(1, 5)) begin
			k = ($urandom_range(0, 9) < 6) ? a : int'($urandom_range(0, 7));
			d = int'($urandom_range(0, cur_thresh / 4));
			if ($urandom_range(0, 1) == 1)
				d = -d;
			push_req(sample_at(k, clamp16(int'(sent_val[k]) + d)));
			sent++;
		end
		if ($urandom_range(0, 3) != 0) begin
			d = int'(cur_thresh) + int'($urandom_range(0, 40));
			tv = int'(sent_val[a]) + d;
			if (tv > 32767)
				tv = int'(sent_val[a]) - d;
			push_req(sample_at(a, clamp16(tv)));
		end else begin
			// break the session off with whatever comes
			push_req(random_req());
		end
		sent++;
	endtask

	task automatic run_traffic(input int n);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 5) == 0) begin
				learn_session(sent);
			end else begin
				push_req(random_req());
				sent++;
			end
			// now and then let every result come back before going on
			if ($urandom_range(0, 199) == 0)
				drain();
		end
	endtask

	// New register setting, then a restore so the new defaults take hold
	task automatic run_phase(input int count, input int tilt, input int zoom,
			input int thr, input int n);
		drain();
		write_reg(CFG_AXIS_COUNT, {12'($urandom), 4'(count)});
		write_reg(CFG_DEFAULT_TILT, {13'($urandom), 3'(tilt)});
		write_reg(CFG_DEFAULT_ZOOM, {13'($urandom), 3'(zoom)});
		write_reg(CFG_THRESHOLD, 16'(thr));
		cur_count = 4'(count);
		cur_thresh = 16'(thr);
		push_req(build_req(MODE_RESTORE, $urandom, $urandom, $urandom_range(0, 1)));
		run_traffic(n);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 8; i++)
			sent_val[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset setting: tilt on axis 0, zoom on axis 1
		push_req(sample_at(0, 32767));            // full tilt up
		push_req(sample_at(0, -32768));           // full tilt down
		push_req(sample_at(0, -32768));           // same value, no change
		push_req(sample_at(1, 1));                // rounds to zero percent
		push_req(sample_at(1, -328));             // just under minus one percent
		push_req(sample_at(2, 1000));             // unmapped axis
		push_req(build_req(MODE_UNUSED_LO, 0, 0, 1));
		push_req(build_req(MODE_UNUSED_HI, 7, -1, 0));
		push_req(build_req(MODE_CANCEL, 0, 0, 0));  // cancel while idle
		push_req(build_req(MODE_BEGIN, 0, 0, 1));   // stops both commands
		push_req(sample_at(3, 5000));             // first sample becomes baseline
		push_req(sample_at(3, 21383));            // one short of the threshold
		push_req(sample_at(2, 17384));            // exactly the threshold: capture zoom
		push_req(build_req(MODE_BEGIN, 5, 0, 0));
		push_req(build_req(MODE_BEGIN, 6, 0, 1));   // restart while learning
		push_req(sample_at(2, -20000));           // capture the axis zoom already has
		push_req(build_req(MODE_BEGIN, 0, 0, 0));
		push_req(sample_at(2, 17384));            // capture for tilt, swap with zoom
		push_req(build_req(MODE_SET, 7, 0, 0));
		push_req(build_req(MODE_SET, 7, 0, 1));     // conflict: swap mapping
		push_req(build_req(MODE_SET, 7, 0, 1));     // already mapped, no change
		push_req(sample_at(7, 32767));
		push_req(build_req(MODE_RESTORE, 0, 0, 0));
		push_req(build_req(MODE_RESTORE, 0, 0, 1)); // restore onto itself
		push_req(sample_at(0, 0));

		// Random part over several settings, extremes among them
		run_phase(8, 0, 1, 16384, 200);
		run_phase(4, 2, 3, 1000, 200);
		run_phase(0, 0, 1, 100, 50);       // no axes at all
		run_phase(1, 0, 0, 0, 200);        // zero threshold, clashing defaults
		run_phase(2, 1, 1, 65535, 200);    // widest threshold
		run_phase(15, 7, 6, 8000, 200);    // count above the axis total
		run_phase(3, 5, 2, 3000, 200);     // default tilt out of range
		run_phase(8, 7, 0, 20000, 200);
		run_phase(9, 3, 3, 500, 200);

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
